@@ design/hpd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, codes and character tables of the HTTP response deframer.
// ----------------------------------------------------------------------------
package hpd_pkg;

  localparam int LINE_MAX = 256;
  localparam int LPW      = $clog2(LINE_MAX + 1);

  localparam int PL_HTTP = 7;
  localparam int PL_CL   = 15;
  localparam int PL_TE   = 18;
  localparam int WORD_LEN    = 7;
  localparam int CARRIER_LEN = 10;

  localparam logic [16:0] BODY_LIMIT_RST = 17'd8192;

  localparam logic [8*PL_HTTP-1:0]     HTTP_TXT    = "HTTP/1.";
  localparam logic [8*PL_CL-1:0]       CL_TXT      = "Content-Length:";
  localparam logic [8*PL_TE-1:0]       TE_TXT      = "Transfer-Encoding:";
  localparam logic [8*WORD_LEN-1:0]    WORD_TXT    = "chunked";
  localparam logic [8*CARRIER_LEN-1:0] CARRIER_TXT = "NO CARRIER";

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  localparam logic [1:0] KIND_BODY      = 2'd0;
  localparam logic [1:0] KIND_DONE      = 2'd1;
  localparam logic [1:0] KIND_NO_STATUS = 2'd2;
  localparam logic [1:0] KIND_DROPPED   = 2'd3;

  // field parse steps
  localparam logic [2:0] FS_START = 3'd0;
  localparam logic [2:0] FS_SIGN1 = 3'd1;
  localparam logic [2:0] FS_DIG1  = 3'd2;
  localparam logic [2:0] FS_WS    = 3'd3;
  localparam logic [2:0] FS_SIGN2 = 3'd4;
  localparam logic [2:0] FS_DIG2  = 3'd5;
  localparam logic [2:0] FS_DONE  = 3'd6;
  localparam logic [2:0] FS_FAIL  = 3'd7;
  localparam logic [2:0] FS_WORD  = 3'd1;
  localparam logic [2:0] FS_AFTER = 3'd2;

  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_WAIT_END,
    PH_CHUNK_SIZE,
    PH_CHUNK_DATA,
    PH_CHUNK_TAIL
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_cr;
    logic       is_lf;
    logic       is_ws;
    logic       is_dec;
    logic       is_sign;
    logic       is_minus;
    logic [4:0] hexv;
  } byte_class_t;

  function automatic logic [7:0] http_char(input logic [2:0] i);
    return HTTP_TXT[8*(PL_HTTP-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] i);
    return CL_TXT[8*(PL_CL-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] i);
    return TE_TXT[8*(PL_TE-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] i);
    return WORD_TXT[8*(WORD_LEN-1-int'(i)) +: 8];
  endfunction

  function automatic logic [7:0] carrier_char(input logic [3:0] i);
    return CARRIER_TXT[8*(CARRIER_LEN-1-int'(i)) +: 8];
  endfunction

endpackage

@@ design/hpd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_front
// Accepts received bytes, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module hpd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  output logic                q_valid,
  output hpd_pkg::byte_class_t q_item,
  input  logic                q_pop
);

  hpd_pkg::byte_class_t cls;
  hpd_pkg::byte_class_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    cls.data     = rx_byte;
    cls.is_cr    = (rx_byte == hpd_pkg::CH_CR);
    cls.is_lf    = (rx_byte == hpd_pkg::CH_LF);
    cls.is_ws    = (rx_byte == 8'd32) || (rx_byte >= 8'd9 && rx_byte <= 8'd13);
    cls.is_dec   = (rx_byte >= "0" && rx_byte <= "9");
    cls.is_sign  = (rx_byte == "+") || (rx_byte == "-");
    cls.is_minus = (rx_byte == "-");
    if (rx_byte >= "0" && rx_byte <= "9") begin
      cls.hexv = 5'(rx_byte - 8'd48);
    end else if (rx_byte >= "a" && rx_byte <= "f") begin
      cls.hexv = 5'(rx_byte - 8'd87);
    end else if (rx_byte >= "A" && rx_byte <= "F") begin
      cls.hexv = 5'(rx_byte - 8'd55);
    end else begin
      cls.hexv = hpd_pkg::HEX_NONE;
    end
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ design/hpd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_back
// Header matcher, body framer and registered result stage.
// ----------------------------------------------------------------------------
module hpd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [16:0]          cfg_wdata,
  input  logic                 q_valid,
  input  hpd_pkg::byte_class_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [7:0]           body_byte,
  output logic [9:0]           status_code,
  output logic [31:0]          body_count,
  output logic                 chunked
);

  typedef struct packed {
    logic [2:0]  step;
    logic [31:0] acc;
    logic        neg;
  } num_t;

  function automatic num_t num_step(input num_t cur, input hpd_pkg::byte_class_t b,
                                    input logic small_cap);
    num_t        r;
    logic [35:0] prod;
    logic [35:0] cap;
    r    = cur;
    cap  = small_cap ? 36'd999 : 36'hFFFFFFFF;
    prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {32'd0, b.hexv[3:0]};
    case (cur.step)
      hpd_pkg::FS_WS: begin
        if (!b.is_ws) begin
          if (b.is_sign) begin
            r.neg  = b.is_minus;
            r.step = hpd_pkg::FS_SIGN2;
          end else if (b.is_dec) begin
            r.acc  = {28'd0, b.hexv[3:0]};
            r.step = hpd_pkg::FS_DIG2;
          end else begin
            r.step = hpd_pkg::FS_FAIL;
          end
        end
      end
      hpd_pkg::FS_SIGN2: begin
        if (b.is_dec) begin
          r.acc  = {28'd0, b.hexv[3:0]};
          r.step = hpd_pkg::FS_DIG2;
        end else begin
          r.step = hpd_pkg::FS_FAIL;
        end
      end
      hpd_pkg::FS_DIG2: begin
        if (b.is_dec) begin
          r.acc = (prod > cap) ? cap[31:0] : prod[31:0];
        end else begin
          r.step = hpd_pkg::FS_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  localparam logic [hpd_pkg::LPW-1:0] POS_MAX = hpd_pkg::LPW'(hpd_pkg::LINE_MAX);

  hpd_pkg::phase_t           phase, phase_next;
  logic                      prev_cr, prev_cr_next;
  logic [hpd_pkg::LPW-1:0]   line_pos, line_pos_next;
  logic [2:0]                flags, flags_next;
  logic [2:0]                fstep, fstep_next;
  logic [2:0]                wprog, wprog_next;
  logic [3:0]                ncprog, ncprog_next;
  logic                      num_neg, num_neg_next;
  logic                      seen, seen_next;
  logic [9:0]                sval, sval_next;
  logic [31:0]               decl, decl_next;
  logic                      chunked_mode, chunked_mode_next;
  logic [31:0]               remaining, remaining_next;
  logic [31:0]               recv, recv_next;
  logic [31:0]               acc, acc_next;
  logic [16:0]               body_limit;

  hpd_pkg::byte_class_t b;
  logic        term;
  logic        got;
  logic        deliver_now;
  logic [31:0] recv_upd;
  logic        rem_last;
  logic        blank;
  logic        status_ok;
  logic        num_ok;
  logic        fin_status, fin_len, fin_te, drop;
  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_data;
  logic        resp_clear;

  assign b        = q_item;
  assign q_pop    = q_valid && (!out_valid || out_ready);
  assign term     = b.is_lf && prev_cr;
  assign got      = ({1'b0, recv} + 33'd1) < {16'd0, body_limit};
  assign deliver_now = got && (phase == hpd_pkg::PH_LENGTH || phase == hpd_pkg::PH_CHUNK_DATA);
  assign recv_upd = recv + 32'(deliver_now);
  assign rem_last = (remaining <= 32'd1);
  assign blank    = (line_pos == hpd_pkg::LPW'(1));
  assign status_ok = seen && (sval != 10'd0);
  assign num_ok   = (fstep == hpd_pkg::FS_DIG2) || (fstep == hpd_pkg::FS_DONE);
  assign fin_status = flags[0] && (line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_HTTP)) && num_ok;
  assign fin_len  = !fin_status && flags[1] &&
                    (line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_CL)) && num_ok;
  assign fin_te   = !fin_status && !fin_len && flags[2] &&
                    (line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_TE));
  assign drop     = !(fin_status || fin_len || fin_te) &&
                    (ncprog == 4'(hpd_pkg::CARRIER_LEN));

  // result decode
  always_comb begin
    res_valid = 1'b0;
    res_kind  = hpd_pkg::KIND_BODY;
    res_data  = 8'd0;
    unique case (phase)
      hpd_pkg::PH_HEADER: begin
        if (term && blank && !status_ok) begin
          res_valid = 1'b1;
          res_kind  = hpd_pkg::KIND_NO_STATUS;
        end else if (term && !blank && drop) begin
          res_valid = 1'b1;
          res_kind  = hpd_pkg::KIND_DROPPED;
        end
      end
      hpd_pkg::PH_LENGTH: begin
        if (rem_last) begin
          res_valid = 1'b1;
          res_kind  = hpd_pkg::KIND_DONE;
          res_data  = got ? b.data : 8'd0;
        end else if (got) begin
          res_valid = 1'b1;
          res_data  = b.data;
        end
      end
      hpd_pkg::PH_WAIT_END: begin
        if (term) begin
          res_valid = 1'b1;
          res_kind  = hpd_pkg::KIND_DONE;
        end
      end
      hpd_pkg::PH_CHUNK_DATA: begin
        if (got) begin
          res_valid = 1'b1;
          res_data  = b.data;
        end
      end
      default: ;
    endcase
  end

  assign resp_clear = res_valid && (res_kind != hpd_pkg::KIND_BODY);

  // next state
  always_comb begin
    num_t nr;
    logic line_clear;
    nr = '{step: fstep, acc: acc, neg: num_neg};
    line_clear        = 1'b0;
    phase_next        = phase;
    prev_cr_next      = b.is_cr;
    line_pos_next     = line_pos;
    flags_next        = flags;
    wprog_next        = wprog;
    ncprog_next       = ncprog;
    seen_next         = seen;
    sval_next         = sval;
    decl_next         = decl;
    chunked_mode_next = chunked_mode;
    remaining_next    = remaining;
    recv_next         = recv_upd;

    unique case (phase)
      hpd_pkg::PH_HEADER: begin
        if (term) begin
          line_clear = 1'b1;
          if (blank) begin
            prev_cr_next = 1'b0;
            if (chunked_mode) begin
              phase_next = hpd_pkg::PH_CHUNK_SIZE;
            end else if (decl != 32'd0) begin
              remaining_next = decl;
              phase_next     = hpd_pkg::PH_LENGTH;
            end else begin
              phase_next = hpd_pkg::PH_WAIT_END;
            end
          end else begin
            if (fin_status) begin
              seen_next = 1'b1;
              sval_next = num_neg ? 10'd0 : acc[9:0];
            end
            if (fin_len) begin
              decl_next = num_neg ? 32'd0 : acc;
            end
            if (fin_te && wprog == 3'(hpd_pkg::WORD_LEN)) begin
              chunked_mode_next = 1'b1;
            end
          end
        end else if (line_pos < POS_MAX) begin
          line_pos_next = line_pos + hpd_pkg::LPW'(1);
          if (line_pos < hpd_pkg::LPW'(hpd_pkg::PL_HTTP) &&
              b.data != hpd_pkg::http_char(line_pos[2:0])) begin
            flags_next[0] = 1'b0;
          end
          if (line_pos < hpd_pkg::LPW'(hpd_pkg::PL_CL) &&
              b.data != hpd_pkg::cl_char(line_pos[3:0])) begin
            flags_next[1] = 1'b0;
          end
          if (line_pos < hpd_pkg::LPW'(hpd_pkg::PL_TE) &&
              b.data != hpd_pkg::te_char(line_pos[4:0])) begin
            flags_next[2] = 1'b0;
          end
          if (flags[0] && line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_HTTP)) begin
            case (fstep)
              hpd_pkg::FS_START: begin
                if (!b.is_ws) begin
                  if (b.is_sign) nr.step = hpd_pkg::FS_SIGN1;
                  else if (b.is_dec) nr.step = hpd_pkg::FS_DIG1;
                  else nr.step = hpd_pkg::FS_FAIL;
                end
              end
              hpd_pkg::FS_SIGN1: begin
                nr.step = b.is_dec ? hpd_pkg::FS_DIG1 : hpd_pkg::FS_FAIL;
              end
              hpd_pkg::FS_DIG1: begin
                if (!b.is_dec) begin
                  if (b.is_ws) begin
                    nr.step = hpd_pkg::FS_WS;
                  end else if (b.is_sign) begin
                    nr.neg  = b.is_minus;
                    nr.step = hpd_pkg::FS_SIGN2;
                  end else begin
                    nr.step = hpd_pkg::FS_FAIL;
                  end
                end
              end
              default: nr = num_step(nr, b, 1'b1);
            endcase
          end else if (flags[1] && line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_CL)) begin
            if (nr.step == hpd_pkg::FS_START) nr.step = hpd_pkg::FS_WS;
            nr = num_step(nr, b, 1'b0);
          end else if (flags[2] && line_pos >= hpd_pkg::LPW'(hpd_pkg::PL_TE)) begin
            if (nr.step == hpd_pkg::FS_START && !b.is_ws) nr.step = hpd_pkg::FS_WORD;
            if (nr.step == hpd_pkg::FS_WORD && fstep != hpd_pkg::FS_START) begin
              if (b.is_ws) nr.step = hpd_pkg::FS_AFTER;
            end
            if (nr.step == hpd_pkg::FS_WORD && !b.is_ws &&
                wprog < 3'(hpd_pkg::WORD_LEN)) begin
              if (b.data == hpd_pkg::word_char(wprog)) wprog_next = wprog + 3'd1;
              else wprog_next = (b.data == "c") ? 3'd1 : 3'd0;
            end
          end
          if (ncprog < 4'(hpd_pkg::CARRIER_LEN)) begin
            if (b.data == hpd_pkg::carrier_char(ncprog)) ncprog_next = ncprog + 4'd1;
            else ncprog_next = (b.data == "N") ? 4'd1 : 4'd0;
          end
        end
      end
      hpd_pkg::PH_LENGTH: begin
        remaining_next = remaining - 32'(remaining != 32'd0);
      end
      hpd_pkg::PH_WAIT_END: ;
      hpd_pkg::PH_CHUNK_SIZE: begin
        if (term) begin
          if (acc == 32'd0) begin
            phase_next = hpd_pkg::PH_WAIT_END;
          end else begin
            remaining_next = acc;
            phase_next     = hpd_pkg::PH_CHUNK_DATA;
          end
          nr.acc  = 32'd0;
          nr.step = hpd_pkg::FS_START;
        end else if (!(fstep == hpd_pkg::FS_START && b.is_ws)) begin
          if (fstep < hpd_pkg::FS_DIG1 && b.hexv != hpd_pkg::HEX_NONE) begin
            nr.acc  = (acc[31:28] != 4'd0) ? 32'hFFFFFFFF : {acc[27:0], b.hexv[3:0]};
            nr.step = hpd_pkg::FS_SIGN1;
          end else begin
            nr.step = hpd_pkg::FS_DIG1;
          end
        end
      end
      hpd_pkg::PH_CHUNK_DATA: begin
        remaining_next = remaining - 32'(remaining != 32'd0);
        if (rem_last) begin
          phase_next   = hpd_pkg::PH_CHUNK_TAIL;
          prev_cr_next = 1'b0;
        end
      end
      hpd_pkg::PH_CHUNK_TAIL: begin
        if (term) phase_next = hpd_pkg::PH_CHUNK_SIZE;
      end
      default: ;
    endcase

    fstep_next   = nr.step;
    acc_next     = nr.acc;
    num_neg_next = nr.neg;

    if (line_clear || resp_clear) begin
      line_pos_next = '0;
      flags_next    = 3'b111;
      fstep_next    = hpd_pkg::FS_START;
      wprog_next    = 3'd0;
      ncprog_next   = 4'd0;
      num_neg_next  = 1'b0;
      acc_next      = 32'd0;
    end
    if (resp_clear) begin
      phase_next        = hpd_pkg::PH_HEADER;
      prev_cr_next      = 1'b0;
      seen_next         = 1'b0;
      sval_next         = 10'd0;
      decl_next         = 32'd0;
      chunked_mode_next = 1'b0;
      remaining_next    = 32'd0;
      recv_next         = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hpd_pkg::PH_HEADER;
      prev_cr      <= 1'b0;
      line_pos     <= '0;
      flags        <= 3'b111;
      fstep        <= hpd_pkg::FS_START;
      wprog        <= 3'd0;
      ncprog       <= 4'd0;
      num_neg      <= 1'b0;
      seen         <= 1'b0;
      sval         <= 10'd0;
      decl         <= 32'd0;
      chunked_mode <= 1'b0;
      remaining    <= 32'd0;
      recv         <= 32'd0;
      acc          <= 32'd0;
    end else if (q_pop) begin
      phase        <= phase_next;
      prev_cr      <= prev_cr_next;
      line_pos     <= line_pos_next;
      flags        <= flags_next;
      fstep        <= fstep_next;
      wprog        <= wprog_next;
      ncprog       <= ncprog_next;
      num_neg      <= num_neg_next;
      seen         <= seen_next;
      sval         <= sval_next;
      decl         <= decl_next;
      chunked_mode <= chunked_mode_next;
      remaining    <= remaining_next;
      recv         <= recv_next;
      acc          <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit <= hpd_pkg::BODY_LIMIT_RST;
    end else if (cfg_we) begin
      body_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      kind        <= res_kind;
      body_byte   <= res_data;
      status_code <= sval;
      body_count  <= recv_upd;
      chunked     <= chunked_mode;
    end
  end

endmodule

@@ design/http_response_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_deframer_core
// Byte-serial HTTP/1.x response deframer: header matcher and body framer.
// ----------------------------------------------------------------------------
// An accepted byte is held in the byte queue until hpd_back pops it; its result is then registered.
// Throughput: 1 byte per cycle while the output is not stalled; hpd_back parses each byte as it pops it.
// A 2-entry byte queue lets input and output stall independently.
// Reset (rst, synchronous) empties the queue, returns the parser to the header
// phase and sets body_limit to 8192.
module http_response_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  body_byte,
  output logic [9:0]  status_code,
  output logic [31:0] body_count,
  output logic        chunked
);

  logic                 q_valid;
  logic                 q_pop;
  hpd_pkg::byte_class_t q_item;

  hpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hpd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .body_byte   (body_byte),
    .status_code (status_code),
    .body_count  (body_count),
    .chunked     (chunked)
  );

endmodule

@@ design/hpd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level checks of the deframer's result channel.
// ----------------------------------------------------------------------------
module hpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [31:0] body_count
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(kind) && $stable(body_count))
    else $error("result transaction changed while stalled");

  a_body_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == hpd_pkg::KIND_BODY |-> body_count != 32'd0)
    else $error("body byte not counted");

  a_header_no_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == hpd_pkg::KIND_NO_STATUS || kind == hpd_pkg::KIND_DROPPED)
    |-> body_count == 32'd0)
    else $error("header result carries body count");

endmodule

bind http_response_deframer_core hpd_checker u_hpd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .body_count (body_count)
);

@@ tb/sv/tb_http_response_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_response_deframer_core
// Self-checking bench for the HTTP response deframer. Header, length, chunked
// and close-by-CRLF responses, a missing status and a dropped link are sent
// as byte transactions under random bursts and output stalls. A software
// deframer predicts every result, and results are compared field by field.
// ----------------------------------------------------------------------------
module tb_http_response_deframer_core;

  localparam logic [1:0] HX_NONE   = 2'd0;
  localparam logic [1:0] HX_DIGITS = 2'd1;
  localparam logic [1:0] HX_SKIP   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [9:0]  status;
    logic [31:0] count;
    logic        chunked;
  } frame_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [16:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  kind;
  logic [7:0]  body_byte;
  logic [9:0]  status_code;
  logic [31:0] body_count;
  logic        chunked;

  http_response_deframer_core uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
    .body_byte(body_byte), .status_code(status_code), .body_count(body_count),
    .chunked(chunked)
  );

  frame_result_t pending_results[$];
  int errors = 0;
  int bytes_sent = 0;
  int burst_left = 0;

  // deframer shadow state
  logic [31:0]      lim;
  hpd_pkg::phase_t  ph;
  logic             pcr;
  int unsigned      lpos;
  logic [2:0]       pmf;
  logic [2:0]       fstep;
  logic [2:0]       wprog;
  logic [3:0]       ncprog;
  logic             neg;
  logic             sseen;
  logic [31:0]      sval;
  logic [31:0]      dlen;
  logic             cmode;
  logic [31:0]      brem;
  logic [31:0]      rcount;
  logic [31:0]      acc;

  string       pfx[3] = '{"HTTP/1.", "Content-Length:", "Transfer-Encoding:"};
  int unsigned plen[3] = '{7, 15, 18};
  string       word = "chunked";
  string       carrier = "NO CARRIER";

  function automatic bit is_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] c);
    if (is_digit(c)) return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return hpd_pkg::HEX_NONE;
  endfunction

  function automatic logic [31:0] dec_acc(logic [31:0] a, logic [31:0] d, logic [31:0] cap);
    if (a > (cap - d) / 10) return cap;
    return a * 10 + d;
  endfunction

  function automatic logic [31:0] hex_acc(logic [31:0] a, logic [31:0] d);
    if (a > (32'hFFFF_FFFF - d) / 16) return 32'hFFFF_FFFF;
    return a * 16 + d;
  endfunction

  function automatic void clear_line();
    lpos = 0; pmf = 3'b111; fstep = hpd_pkg::FS_START; wprog = 0; ncprog = 0;
    neg = 0; acc = 0;
  endfunction

  function automatic void clear_response();
    ph = hpd_pkg::PH_HEADER; pcr = 0; clear_line();
    sseen = 0; sval = 0; dlen = 0; cmode = 0; brem = 0; rcount = 0;
  endfunction

  function automatic void number_step(logic [7:0] c, logic [31:0] cap);
    case (fstep)
      hpd_pkg::FS_WS: begin
        if (is_space(c)) ;
        else if (c == "+" || c == "-") begin
          neg = (c == "-"); fstep = hpd_pkg::FS_SIGN2;
        end else if (is_digit(c)) begin
          acc = 32'(c - "0"); fstep = hpd_pkg::FS_DIG2;
        end else fstep = hpd_pkg::FS_FAIL;
      end
      hpd_pkg::FS_SIGN2: begin
        if (is_digit(c)) begin
          acc = 32'(c - "0"); fstep = hpd_pkg::FS_DIG2;
        end else fstep = hpd_pkg::FS_FAIL;
      end
      hpd_pkg::FS_DIG2: begin
        if (is_digit(c)) acc = dec_acc(acc, 32'(c - "0"), cap);
        else fstep = hpd_pkg::FS_DONE;
      end
      default: ;
    endcase
  endfunction

  function automatic void status_field(logic [7:0] c);
    case (fstep)
      hpd_pkg::FS_START: begin
        if (is_space(c)) ;
        else if (c == "+" || c == "-") fstep = hpd_pkg::FS_SIGN1;
        else if (is_digit(c)) fstep = hpd_pkg::FS_DIG1;
        else fstep = hpd_pkg::FS_FAIL;
      end
      hpd_pkg::FS_SIGN1: fstep = is_digit(c) ? hpd_pkg::FS_DIG1 : hpd_pkg::FS_FAIL;
      hpd_pkg::FS_DIG1: begin
        if (is_digit(c)) ;
        else if (is_space(c)) fstep = hpd_pkg::FS_WS;
        else if (c == "+" || c == "-") begin
          neg = (c == "-"); fstep = hpd_pkg::FS_SIGN2;
        end else fstep = hpd_pkg::FS_FAIL;
      end
      default: number_step(c, 32'd999);
    endcase
  endfunction

  function automatic void coding_field(logic [7:0] c);
    if (fstep == hpd_pkg::FS_START) begin
      if (is_space(c)) return;
      fstep = hpd_pkg::FS_WORD;
    end
    if (fstep != hpd_pkg::FS_WORD) return;
    if (is_space(c)) begin
      fstep = hpd_pkg::FS_AFTER;
      return;
    end
    if (wprog < hpd_pkg::WORD_LEN) begin
      if (c == word[wprog]) wprog++;
      else wprog = (c == "c") ? 3'd1 : 3'd0;
    end
  endfunction

  function automatic void feed_header(logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (!pmf[k]) continue;
      if (lpos < plen[k]) begin
        if (c != pfx[k][lpos]) pmf[k] = 1'b0;
      end else if (k == 0) status_field(c);
      else if (k == 1) begin
        if (fstep == hpd_pkg::FS_START) fstep = hpd_pkg::FS_WS;
        number_step(c, 32'hFFFF_FFFF);
      end else coding_field(c);
    end
    if (ncprog < hpd_pkg::CARRIER_LEN) begin
      if (c == carrier[ncprog]) ncprog++;
      else ncprog = (c == "N") ? 4'd1 : 4'd0;
    end
  endfunction

  function automatic bit close_line_dropped();
    bit num_ok = (fstep == hpd_pkg::FS_DIG2 || fstep == hpd_pkg::FS_DONE);
    bit hit = 0;
    if (pmf[0] && lpos >= plen[0] && num_ok) begin
      sseen = 1; sval = neg ? 0 : acc; hit = 1;
    end else if (pmf[1] && lpos >= plen[1] && num_ok) begin
      dlen = neg ? 0 : acc; hit = 1;
    end else if (pmf[2] && lpos >= plen[2]) begin
      if (wprog == hpd_pkg::WORD_LEN) cmode = 1;
      hit = 1;
    end
    return !hit && ncprog == hpd_pkg::CARRIER_LEN;
  endfunction

  function automatic bit take_body();
    if (rcount + 1 < lim) begin
      rcount++;
      return 1;
    end
    return 0;
  endfunction

  function automatic bit deframe_byte(logic [7:0] c, output frame_result_t r);
    bit term = (c == hpd_pkg::CH_LF) && pcr;
    bit hit = 0;
    bit got;
    logic [1:0] k = hpd_pkg::KIND_BODY;
    logic [7:0] d = 0;
    logic [4:0] hv;
    pcr = (c == hpd_pkg::CH_CR);
    case (ph)
      hpd_pkg::PH_HEADER: begin
        if (term) begin
          if (lpos == 1) begin
            clear_line(); pcr = 0;
            if (!sseen || sval == 0) begin
              hit = 1; k = hpd_pkg::KIND_NO_STATUS;
            end else if (cmode) ph = hpd_pkg::PH_CHUNK_SIZE;
            else if (dlen > 0) begin
              brem = dlen; ph = hpd_pkg::PH_LENGTH;
            end else ph = hpd_pkg::PH_WAIT_END;
          end else begin
            if (close_line_dropped()) begin
              hit = 1; k = hpd_pkg::KIND_DROPPED;
            end
            clear_line();
          end
        end else if (lpos < hpd_pkg::LINE_MAX) begin
          feed_header(c);
          lpos++;
        end
      end
      hpd_pkg::PH_LENGTH: begin
        got = take_body();
        if (brem > 0) brem--;
        if (brem == 0) begin
          hit = 1; k = hpd_pkg::KIND_DONE; d = got ? c : 8'd0;
        end else if (got) begin
          hit = 1; d = c;
        end
      end
      hpd_pkg::PH_WAIT_END: if (term) begin
        hit = 1; k = hpd_pkg::KIND_DONE;
      end
      hpd_pkg::PH_CHUNK_SIZE: begin
        if (term) begin
          if (acc == 0) ph = hpd_pkg::PH_WAIT_END;
          else begin
            brem = acc; ph = hpd_pkg::PH_CHUNK_DATA;
          end
          acc = 0; fstep = HX_NONE;
        end else begin
          hv = hex_val(c);
          if (fstep == HX_NONE && is_space(c)) ;
          else if (fstep < HX_SKIP && hv != hpd_pkg::HEX_NONE) begin
            acc = hex_acc(acc, 32'(hv)); fstep = HX_DIGITS;
          end else fstep = HX_SKIP;
        end
      end
      hpd_pkg::PH_CHUNK_DATA: begin
        if (take_body()) begin
          hit = 1; d = c;
        end
        if (brem > 0) brem--;
        if (brem == 0) begin
          ph = hpd_pkg::PH_CHUNK_TAIL; pcr = 0;
        end
      end
      hpd_pkg::PH_CHUNK_TAIL: if (term) ph = hpd_pkg::PH_CHUNK_SIZE;
      default: clear_response();
    endcase
    r = '{kind: k, data: d, status: sval[9:0], count: rcount, chunked: cmode};
    if (hit && k != hpd_pkg::KIND_BODY) clear_response();
    return hit;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: drives out_ready with one of four stall patterns, chosen at random
  int rx_cyc = 0;
  int rx_mode = 0;
  always @(posedge clk) begin
    rx_cyc++;
    if (rx_cyc % 61 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (rx_cyc % 4 != 0);
    endcase
  end

  always @(posedge clk) begin
    frame_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d", $time, kind);
      end else begin
        e = pending_results.pop_front();
        if (kind !== e.kind) begin
          errors++;
          $display("%0t: kind exp %0d got %0d", $time, e.kind, kind);
        end
        if (body_byte !== e.data) begin
          errors++;
          $display("%0t: body_byte exp %0h got %0h", $time, e.data, body_byte);
        end
        if (status_code !== e.status) begin
          errors++;
          $display("%0t: status_code exp %0d got %0d", $time, e.status, status_code);
        end
        if (body_count !== e.count) begin
          errors++;
          $display("%0t: body_count exp %0d got %0d", $time, e.count, body_count);
        end
        if (chunked !== e.chunked) begin
          errors++;
          $display("%0t: chunked exp %0d got %0d", $time, e.chunked, chunked);
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    frame_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_results.push_back(r);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_body_limit(logic [16:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim = 32'(v);
  endtask

  task automatic send_random_bytes(int n, bit no_cr);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = $urandom_range(0, 255);
      if (no_cr && b == hpd_pkg::CH_CR) b = 8'h0D ^ 8'h80;
      send_byte(b);
    end
  endtask

  task test_length_body();
    send_text("HTTP/1.1 200 OK\r\nContent-Length: 5\r\n\r\n");
    send_byte(8'h00); send_byte(8'hFF); send_byte(hpd_pkg::CH_CR);
    send_byte(hpd_pkg::CH_LF);
    send_byte(8'h41);
  endtask

  task test_chunked_body();
    send_text("HTTP/1.1 404 x\r\nTransfer-Encoding: chunked\r\n\r\n");
    send_text("3;ext\r\nabc\r\n  A\r\n0123456789\r\n0\r\n\r\n");
  endtask

  task test_missing_status();
    send_text("\r\n");
    send_text("HTTP/1.1 -5\r\n\r\n");
  endtask

  task test_dropped_link();
    send_text("xxNO CARRIER\r\n");
  endtask

  task test_close_delimited();
    send_text("HTTP/1.0 999999\r\nContent-Length: -3\r\n\r\nab\rc\r\n");
  endtask

  task test_overlong_line();
    for (int i = 0; i < hpd_pkg::LINE_MAX + 20; i++) send_byte("x");
    send_text("\r\nHTTP/1.1 201\r\n\r\n\r\n");
  endtask

  task test_limit_extremes();
    set_body_limit(17'd1);
    send_text("HTTP/1.1 200\r\nContent-Length: 3\r\n\r\nabc");
    set_body_limit(17'd2);
    send_text("HTTP/1.1 200\r\nContent-Length: 3\r\n\r\nabc");
    set_body_limit(17'h10000);
    send_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\nab");
    drain();
  endtask

  task automatic random_response();
    string s;
    string hx;
    int sel;
    int n;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      send_random_bytes($urandom_range(1, 10), 0);
      return;
    end
    s = $sformatf("HTTP/1.%0d %0d\r\n", $urandom_range(0, 1),
                  ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(100, 599));
    if (sel == 1) s = "Server: x\r\n";
    if ($urandom_range(0, 2) == 0)
      s = {s, $sformatf("X-Tag: %0d\r\n", $urandom)};
    n = $urandom_range(0, 30);
    if (sel <= 4) begin
      send_text({s, $sformatf("Content-Length: %0d\r\n\r\n", n)});
      send_random_bytes(n, 0);
      if (n == 0) send_text("\r\n");
    end else if (sel <= 7) begin
      send_text({s, "Transfer-Encoding: chunked\r\n\r\n"});
      repeat ($urandom_range(1, 3)) begin
        n = $urandom_range(1, 20);
        hx = $sformatf("%0h", n);
        if ($urandom_range(0, 1)) hx = hx.toupper();
        send_text({hx, "\r\n"});
        send_random_bytes(n, 0);
        send_text("\r\n");
      end
      send_text("0\r\n\r\n");
    end else begin
      send_text({s, "\r\n"});
      send_random_bytes(n, 1);
      send_text("\r\n");
    end
  endtask

  task automatic test_random_stream();
    int stop;
    logic [16:0] picks[6] = '{17'd1, 17'd2, 17'd5, 17'd12, 17'h10000, 17'd8192};
    stop = bytes_sent + 120;
    while (bytes_sent < stop) begin
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 1)) set_body_limit(picks[$urandom_range(0, 5)]);
        else set_body_limit(17'($urandom_range(1, 65536)));
      end
      random_response();
    end
  endtask

  initial begin
    rst = 1; cfg_we = 0; cfg_wdata = 0; in_valid = 0; rx_byte = 0; out_ready = 0;
    lim = 32'(hpd_pkg::BODY_LIMIT_RST);
    clear_response();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_length_body();
    test_chunked_body();
    test_missing_status();
    test_dropped_link();
    test_close_delimited();
    test_overlong_line();
    test_limit_extremes();
    test_random_stream();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ http_response_deframer_core.f @@
design/hpd_pkg.sv
design/hpd_front.sv
design/hpd_back.sv
design/http_response_deframer_core.sv
design/hpd_checker.sv
tb/sv/tb_http_response_deframer_core.sv
